### rtl/wft_pkg.sv
// wft_pkg: shared types and codes for the word frequency table
// depends on nothing; imported by wft_token, the top level and the bench
package wft_pkg;

    // result status codes
    localparam logic [1:0] STAT_HIT  = 2'd0;
    localparam logic [1:0] STAT_NEW  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    // character bounds
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_CASE    = 8'd32;

    // search sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_META,
        ST_LEN,
        ST_KEY,
        ST_HIT,
        ST_NEW,
        ST_APPEND,
        ST_DONE
    } t_state;

endpackage

### rtl/wft_char_if.sv
// wft_char_if: valid/ready channel carrying one token character per beat
// no dependencies
interface wft_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink (input valid, input ch, input last_char, output ready);
endinterface

### rtl/wft_result_if.sv
// wft_result_if: valid/ready channel carrying one counted-word result per beat
// no dependencies
interface wft_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  entry_index;
    logic [15:0] word_count;
    logic [1:0]  status;

    modport source (output valid, output entry_index, output word_count, output status,
                    input ready);
    modport sink (input valid, input entry_index, input word_count, input status,
                  output ready);
endinterface

### rtl/wft_ram.sv
// wft_ram: simple dual-port synchronous ram, one write and one registered read
// no dependencies
module wft_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/wft_token.sv
// wft_token: collects and normalizes the characters of the current token
// depends on wft_pkg
module wft_token #(
    parameter int MAX_WORD_LEN = 29
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [7:0]                        i_ch,
    input  logic                              i_clear,
    input  logic [$clog2(MAX_WORD_LEN)-1:0]   i_idx,
    output logic [7:0]                        o_ch,
    output logic [$clog2(MAX_WORD_LEN+1)-1:0] o_len
);
    import wft_pkg::*;

    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int IW = $clog2(MAX_WORD_LEN);

    logic [7:0]    r_buf [MAX_WORD_LEN];
    logic [LW-1:0] r_len, n_len;
    logic          r_cut, n_cut;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_ch;

    // take one character: lowercase the first, cut at the first non a-z after it
    always_comb begin
        n_len  = r_len;
        n_cut  = r_cut;
        wr_en  = 1'b0;
        wr_idx = r_len[IW-1:0];
        wr_ch  = i_ch;
        if (i_clear) begin
            n_len = '0;
            n_cut = 1'b0;
        end else if (i_take && !r_cut) begin
            if (r_len == '0) begin
                if (i_ch == 8'd0) begin
                    n_cut = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    if (i_ch >= CH_UPPER_A && i_ch <= CH_UPPER_Z) begin
                        wr_ch = i_ch + CH_CASE;
                    end
                    n_len = LW'(1);
                end
            end else if (i_ch < CH_LOWER_A || i_ch > CH_LOWER_Z) begin
                n_cut = 1'b1;
            end else if (r_len < LW'(MAX_WORD_LEN)) begin
                wr_en = 1'b1;
                n_len = r_len + LW'(1);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_cut <= 1'b0;
        end else begin
            r_len <= n_len;
            r_cut <= n_cut;
        end
    end

    // character buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[wr_idx] <= wr_ch;
        end
    end

    assign o_ch  = r_buf[i_idx];
    assign o_len = r_len;
endmodule

### rtl/word_frequency_table_top.sv
// word_frequency_table_top: token normalizer, key and entry memories, search sequencer
// depends on wft_pkg, wft_char_if, wft_result_if, wft_ram, wft_token
//
// Characters are taken one per cycle while the sequencer is idle in ST_IDLE.
// After the last character of a token the sequencer walks the stored words in
// insertion order: ST_META reads a slot's length, ST_LEN compares it, and a slot
// of equal length is compared one character at a time in ST_KEY until the first
// mismatch or the last character. A hit then updates the count in ST_HIT; a new
// word writes its length and count in ST_NEW and its key in ST_APPEND; a full
// table gives STAT_FULL. ST_DONE moves the result to the output register, which a
// waiting result holds while the next token's characters are already taken. No
// clearing pass after reset: only slots below the fill count are ever read.
module word_frequency_table_top #(
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_WORD_LEN = 29,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    wft_char_if.sink     i_char,
    wft_result_if.source o_res
);
    import wft_pkg::*;

    localparam int LW = $clog2(MAX_WORD_LEN + 1);
    localparam int IW = $clog2(MAX_WORD_LEN);
    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int UW = $clog2(MAX_ENTRIES + 1);
    localparam int KD = MAX_ENTRIES * MAX_WORD_LEN;
    localparam int KW = $clog2(KD);
    localparam int MW = LW + COUNT_WIDTH;

    t_state           r_state, n_state;
    logic [SW-1:0]    r_slot, n_slot;
    logic [KW-1:0]    r_base, n_base;
    logic [IW-1:0]    r_idx, n_idx;
    logic [UW-1:0]    r_used, n_used;
    logic [7:0]       r_res_idx, n_res_idx;
    logic [15:0]      r_res_cnt, n_res_cnt;
    logic [1:0]       r_res_stat, n_res_stat;
    logic             r_out_valid;

    logic             take, tok_clear, out_load, miss;
    logic [IW-1:0]    tok_idx;
    logic [7:0]       tok_ch;
    logic [LW-1:0]    tok_len;
    logic             key_we;
    logic [KW-1:0]    key_waddr, key_raddr;
    logic [7:0]       key_rdata;
    logic             meta_we;
    logic [SW-1:0]    meta_waddr;
    logic [MW-1:0]    meta_wdata, meta_rdata;
    logic [LW-1:0]    meta_len;
    logic [COUNT_WIDTH-1:0] meta_cnt, cnt_inc;

    assign i_char.ready = (r_state == ST_IDLE);
    assign take         = i_char.valid && i_char.ready;

    // token front end
    wft_token #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_token (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_ch    (i_char.ch),
        .i_clear (tok_clear),
        .i_idx   (tok_idx),
        .o_ch    (tok_ch),
        .o_len   (tok_len)
    );

    // stored key characters, MAX_WORD_LEN per slot
    wft_ram #(.W(8), .D(KD)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (tok_ch),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    // per-slot length and count, read continuously at the current slot
    wft_ram #(.W(MW), .D(MAX_ENTRIES)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (r_slot),
        .o_rdata (meta_rdata)
    );

    assign meta_len = meta_rdata[MW-1:COUNT_WIDTH];
    assign meta_cnt = meta_rdata[COUNT_WIDTH-1:0];
    assign cnt_inc  = (meta_cnt == '1) ? meta_cnt : meta_cnt + COUNT_WIDTH'(1);

    // search sequencer
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_base     = r_base;
        n_idx      = r_idx;
        n_used     = r_used;
        n_res_idx  = r_res_idx;
        n_res_cnt  = r_res_cnt;
        n_res_stat = r_res_stat;
        key_we     = 1'b0;
        key_waddr  = r_base + KW'(r_idx);
        key_raddr  = r_base;
        meta_we    = 1'b0;
        meta_waddr = r_slot;
        meta_wdata = {tok_len, cnt_inc};
        tok_clear  = 1'b0;
        tok_idx    = r_idx;
        out_load   = 1'b0;
        miss       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (take && i_char.last_char) begin
                    n_slot  = '0;
                    n_base  = '0;
                    n_state = (r_used == '0) ? ST_NEW : ST_META;
                end
            end
            ST_META: begin
                n_state = ST_LEN;
            end
            ST_LEN: begin
                n_idx = '0;
                if (meta_len != tok_len) begin
                    miss = 1'b1;
                end else if (tok_len == '0) begin
                    n_state = ST_HIT;
                end else begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                key_raddr = r_base + KW'(r_idx) + KW'(1);
                if (key_rdata != tok_ch) begin
                    miss = 1'b1;
                end else if (LW'(r_idx) + LW'(1) == tok_len) begin
                    n_state = ST_HIT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_HIT: begin
                meta_we    = 1'b1;
                n_res_idx  = 8'(r_slot);
                n_res_cnt  = 16'(cnt_inc);
                n_res_stat = STAT_HIT;
                n_state    = ST_DONE;
            end
            ST_NEW: begin
                meta_we    = 1'b1;
                meta_waddr = SW'(r_used);
                meta_wdata = {tok_len, COUNT_WIDTH'(1)};
                n_res_idx  = 8'(r_used);
                n_res_cnt  = 16'd1;
                n_res_stat = STAT_NEW;
                n_used     = r_used + UW'(1);
                n_idx      = '0;
                n_state    = (tok_len == '0) ? ST_DONE : ST_APPEND;
            end
            ST_APPEND: begin
                key_we = 1'b1;
                if (LW'(r_idx) + LW'(1) == tok_len) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load  = 1'b1;
                    tok_clear = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // move on to the next slot, or decide the word is new or the table is full
        if (miss) begin
            n_slot = r_slot + SW'(1);
            n_base = r_base + KW'(MAX_WORD_LEN);
            if (UW'(r_slot) + UW'(1) == r_used) begin
                if (r_used < UW'(MAX_ENTRIES)) begin
                    n_state = ST_NEW;
                end else begin
                    n_res_idx  = '0;
                    n_res_cnt  = '0;
                    n_res_stat = STAT_FULL;
                    n_state    = ST_DONE;
                end
            end else begin
                n_state = ST_META;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= out_load ? 1'b1 : (o_res.ready ? 1'b0 : r_out_valid);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_base     <= n_base;
        r_idx      <= n_idx;
        r_res_idx  <= n_res_idx;
        r_res_cnt  <= n_res_cnt;
        r_res_stat <= n_res_stat;
    end

    // output register
    logic [7:0]  r_o_idx;
    logic [15:0] r_o_cnt;
    logic [1:0]  r_o_stat;

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_idx  <= r_res_idx;
            r_o_cnt  <= r_res_cnt;
            r_o_stat <= r_res_stat;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.entry_index = r_o_idx;
    assign o_res.word_count  = r_o_cnt;
    assign o_res.status      = r_o_stat;
endmodule

### bench/tb_word_frequency_table_top.sv
// tb_word_frequency_table_top: self-checking bench for the word frequency table
// depends on wft_pkg, wft_char_if, wft_result_if and word_frequency_table_top
module tb_word_frequency_table_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wft_pkg::*;

    localparam int N_SLOTS = 256;
    localparam int WORD_MAX = 29;
    localparam int N_RANDOM = 1200;

    typedef struct packed {
        logic [7:0]  entry_index;
        logic [15:0] word_count;
        logic [1:0]  status;
    } t_tally;

    typedef struct {
        logic [7:0] ch;
        logic       last_char;
        logic       known;
        t_tally     tally;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    wft_char_if   char_ch ();
    wft_result_if res_ch ();

    word_frequency_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch.sink),
        .o_res   (res_ch.source)
    );

    // local copy of the word table
    string       stored_words[$];
    int unsigned stored_counts[$];
    string       cur_word;
    logic        cur_cut;
    logic        cur_started;

    t_tally tallies_due[$];
    int     errors;
    logic   rx_stall_ok;

    // normalize one character and, on the last one, look the word up
    function automatic void count_char(input logic [7:0] c, input logic last,
                                       output logic produced, output t_tally res);
        logic [7:0] k;
        int         slot;
        k = c;
        produced = 1'b0;
        res = '0;
        if (!cur_cut) begin
            if (!cur_started) begin
                if (k == 8'd0) begin
                    cur_cut = 1'b1;
                end else begin
                    if (k >= CH_UPPER_A && k <= CH_UPPER_Z) k = k + CH_CASE;
                    cur_word = {cur_word, string'(k)};
                    cur_started = 1'b1;
                end
            end else if (k < CH_LOWER_A || k > CH_LOWER_Z) begin
                cur_cut = 1'b1;
            end else if (cur_word.len() < WORD_MAX) begin
                cur_word = {cur_word, string'(k)};
            end
        end
        if (!last) return;
        produced = 1'b1;
        slot = -1;
        foreach (stored_words[i])
            if (slot < 0 && stored_words[i] == cur_word) slot = i;
        if (slot >= 0) begin
            if (stored_counts[slot] < 65535) stored_counts[slot]++;
            res = '{slot[7:0], stored_counts[slot][15:0], STAT_HIT};
        end else if (stored_words.size() < N_SLOTS) begin
            stored_words.push_back(cur_word);
            stored_counts.push_back(1);
            res = '{8'(stored_words.size() - 1), 16'd1, STAT_NEW};
        end else begin
            res = '{8'd0, 16'd0, STAT_FULL};
        end
        cur_word = "";
        cur_cut = 1'b0;
        cur_started = 1'b0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // drive one beat, check known rows against the model and queue what it should produce; valid stays high afterwards
    task automatic send_char(input logic [7:0] c, input logic last, input logic known,
                             input t_tally want, input logic gaps);
        logic   produced;
        t_tally res;
        if (gaps && $urandom_range(0, 3) == 0) begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.ch        <= c;
        char_ch.last_char <= last;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        count_char(c, last, produced, res);
        if (produced) begin
            if (known && res !== want) begin
                $display("%0t table mismatch: expected %h actual %h", $time, want, res);
                errors++;
            end
            tallies_due.push_back(res);
        end
    endtask

    // drop valid once the sender has nothing more to send for now
    task automatic stop_chars();
        char_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(input string w, input logic gaps);
        for (int i = 0; i < w.len(); i++)
            send_char(w[i], i == w.len() - 1, 1'b0, '0, gaps);
    endtask

    // random character, mostly lowercase letters
    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(65, 90));
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (tallies_due.size() == 0) begin
                $display("%0t unexpected beat: expected none actual %0d/%0d/%0d", $time,
                         res_ch.entry_index, res_ch.word_count, res_ch.status);
                errors++;
            end else begin
                t_tally w;
                w = tallies_due.pop_front();
                if (res_ch.entry_index !== w.entry_index) begin
                    $display("%0t entry_index: expected %0d actual %0d", $time,
                             w.entry_index, res_ch.entry_index);
                    errors++;
                end
                if (res_ch.word_count !== w.word_count) begin
                    $display("%0t word_count: expected %0d actual %0d", $time,
                             w.word_count, res_ch.word_count);
                    errors++;
                end
                if (res_ch.status !== w.status) begin
                    $display("%0t status: expected %0d actual %0d", $time,
                             w.status, res_ch.status);
                    errors++;
                end
            end
        end
    end

    // receiver stalls in short bursts
    initial begin
        res_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (rx_stall_ok && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        #400ms;
        $display("FAIL word_frequency_table_top");
        $finish;
    end

    initial begin
        t_row  rows[$];
        string word;
        int    n;
        logic  paused;
        errors = 0;
        cur_word = "";
        cur_cut = 1'b0;
        cur_started = 1'b0;
        rx_stall_ok = 1'b1;
        paused = 1'b0;
        char_ch.valid <= 1'b0;
        char_ch.ch <= '0;
        char_ch.last_char <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: first words, empty word, cuts, uppercase, extremes
        rows.push_back('{8'h41, 1'b1, 1'b1, '{8'd0, 16'd1, STAT_NEW}});  // "a"
        rows.push_back('{8'h61, 1'b1, 1'b1, '{8'd0, 16'd2, STAT_HIT}});  // "a" again
        rows.push_back('{8'h00, 1'b0, 1'b0, '0});                        // zero first char
        rows.push_back('{8'h62, 1'b1, 1'b1, '{8'd1, 16'd1, STAT_NEW}});  // empty word
        rows.push_back('{8'hff, 1'b1, 1'b1, '{8'd2, 16'd1, STAT_NEW}});  // odd first char
        rows.push_back('{8'h7a, 1'b0, 1'b0, '0});
        rows.push_back('{8'h00, 1'b0, 1'b0, '0});                        // zero cuts
        rows.push_back('{8'h61, 1'b1, 1'b0, '0});
        rows.push_back('{8'h5a, 1'b0, 1'b0, '0});
        rows.push_back('{8'h5a, 1'b0, 1'b0, '0});                        // uppercase cuts
        rows.push_back('{8'h7b, 1'b1, 1'b0, '0});
        foreach (rows[i])
            send_char(rows[i].ch, rows[i].last_char, rows[i].known, rows[i].tally, 1'b0);
        send_word("abcdefghijklmnopqrstuvwxyzabcdefg", 1'b0);  // overlong
        send_word("abcdefghijklmnopqrstuvwxyzabcxyz", 1'b0);   // same first 29
        stop_chars();
        wait (tallies_due.size() == 0);

        // random: words from a small vocabulary so hits occur
        for (int i = 0; i < N_RANDOM; ) begin
            if (!paused && i >= N_RANDOM / 2) begin
                stop_chars();
                wait (tallies_due.size() == 0);
                paused = 1'b1;
            end
            if (i > N_RANDOM * 9 / 10) rx_stall_ok = 1'b0;
            word = "";
            n = $urandom_range(1, 4);
            if ($urandom_range(0, 3) != 0) begin
                for (int j = 0; j < n; j++) word = {word, string'(8'(97 + $urandom_range(0, 3)))};
            end else begin
                n = $urandom_range(1, 32);
                for (int j = 0; j < n; j++) word = {word, string'(rand_letter())};
            end
            send_word(word, i <= N_RANDOM * 9 / 10);
            i += word.len();
        end

        // fill the table with distinct words, then try one new word eight times on a full table
        for (int i = 0; stored_words.size() < N_SLOTS && i < 676; i++)
            send_word({"q", string'(8'(97 + i / 26)), string'(8'(97 + i % 26))}, 1'b0);
        for (int i = 0; i < 8; i++) send_word("zzzzzzzzzzq", 1'b0);

        stop_chars();
        wait (tallies_due.size() == 0);
        repeat (2000) @(posedge i_clk);
        if (errors == 0 && tallies_due.size() == 0)
            $display("PASS word_frequency_table_top");
        else
            $display("FAIL word_frequency_table_top");
        $finish;
    end
endmodule
